@@ design/gbd_pkg.sv @@
// shared constants, types and gamma tables of the gamma-correct box downscaler
package gbd_pkg;

  localparam int IN_WIDTH    = 256;
  localparam int IN_HEIGHT   = 256;
  localparam int LINEAR_BITS = 16;

  localparam int HALF_W = IN_WIDTH / 2;
  localparam int HALF_H = IN_HEIGHT / 2;
  localparam int COL_W  = $clog2(IN_WIDTH);
  localparam int ROW_W  = $clog2(IN_HEIGHT);
  localparam int IDX_W  = (HALF_W > 1) ? $clog2(HALF_W) : 1;
  localparam int PAIR_W = LINEAR_BITS + 1;
  localparam int BLK_W  = LINEAR_BITS + 2;
  localparam int QDEPTH = 4;
  localparam int QCNT_W = $clog2(QDEPTH + 1);
  localparam int QPTR_W = $clog2(QDEPTH);

  typedef logic [LINEAR_BITS-1:0] lin_t;
  typedef lin_t [255:0] lin_tab_t;

  // one finished 2x2 block handed from front to back
  typedef struct packed {
    logic [2:0][BLK_W-1:0] col;
    logic [9:0]            cov;
    logic                  last;
    logic                  mode;
  } blk_t;

  // round to nearest of full scale times x to the power 2.2, halves up
  function automatic lin_t gam(input real x);
    real v;
    v = ((2.0 ** LINEAR_BITS) - 1.0) * (x ** 2.2);
    gam = LINEAR_BITS'(longint'($floor(v + 0.5)));
  endfunction

  function automatic lin_tab_t build_lin();
    lin_tab_t t;
    for (int c = 0; c < 256; c++) begin
      t[c] = gam(real'(c) / 255.0);
    end
    return t;
  endfunction

  // midpoint thresholds between neighbouring output codes
  function automatic lin_tab_t build_thr();
    lin_tab_t t;
    t[0] = '0;
    for (int k = 1; k < 256; k++) begin
      t[k] = gam(real'(2 * k - 1) / 510.0);
    end
    return t;
  endfunction

  localparam lin_tab_t LIN_TAB = build_lin();
  localparam lin_tab_t THR_TAB = build_thr();

endpackage

@@ design/gamma_box_downscale.sv @@
// top level of the gamma-correct 2x2 box downscaler
// Takes one pixel item per cycle in raster order (256x256 frame) and gives one
// half-size pixel item per 2x2 block, on the right pixel of each odd row. The
// input side sustains one item per cycle while the block queue is not full. A
// four-entry block queue parts it from the back end. The back end has an
// eight-stage threshold search pipeline and an output register, and sustains one
// result per cycle while the output is not stalled.
// The line buffer needs no clearing after reset. cfg_data bit 0 sets gamma mode
// (1 after reset); write it only while the block is idle.
module gamma_box_downscale import gbd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_data,      // gamma_enable
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,       // red_in, green_in, blue_in, coverage_in
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,       // red_out, green_out, blue_out, coverage_out
  output logic        m_tlast        // frame_last
);

  logic gamma_enable;
  logic q_full;
  logic q_nonempty;
  logic q_pop;
  logic blk_push;
  logic pix_valid;
  blk_t blk;
  blk_t q_rd;

  assign cfg_ready = 1'b1;
  assign s_tready  = !q_full;
  assign pix_valid = s_tvalid && s_tready;

  // mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      gamma_enable <= 1'b1;
    end else if (cfg_valid) begin
      gamma_enable <= cfg_data[0];
    end
  end

  gbd_front u_front (
    .clk          (clk),
    .rst          (rst),
    .gamma_enable (gamma_enable),
    .pix_valid    (pix_valid),
    .red          (s_tdata[7:0]),
    .green        (s_tdata[15:8]),
    .blue         (s_tdata[23:16]),
    .cov          (s_tdata[31:24]),
    .blk_push     (blk_push),
    .blk          (blk)
  );

  gbd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (blk_push),
    .wr       (blk),
    .full     (q_full),
    .pop      (q_pop),
    .nonempty (q_nonempty),
    .rd       (q_rd)
  );

  gbd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_nonempty (q_nonempty),
    .q_rd       (q_rd),
    .q_pop      (q_pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_data   (m_tdata),
    .out_last   (m_tlast)
  );

endmodule

@@ design/gbd_front.sv @@
// front end: raster position, linearisation, pair sums and line buffer
module gbd_front import gbd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       gamma_enable,
  input  logic       pix_valid,
  input  logic [7:0] red,
  input  logic [7:0] green,
  input  logic [7:0] blue,
  input  logic [7:0] cov,
  output logic       blk_push,
  output blk_t       blk
);

  localparam int ENT_W = 3 * PAIR_W + 9;

  logic [COL_W-1:0] col;
  logic [ROW_W-1:0] row;
  logic [COL_W-1:0] col_next;
  logic [ROW_W-1:0] row_next;
  lin_t [2:0]       pend_col;
  logic [7:0]       pend_cov;
  logic [ENT_W-1:0] line_mem [HALF_W];
  logic [ENT_W-1:0] line_rd;
  lin_t [2:0]       contrib;
  logic [2:0][PAIR_W-1:0] ps;
  logic [8:0]       ps_cov;
  logic [2:0][PAIR_W-1:0] ln_col;
  logic [8:0]       ln_cov;
  logic             in_area;
  logic [IDX_W-1:0] idx;
  logic [7:0]       codes [3];

  assign codes[0] = red;
  assign codes[1] = green;
  assign codes[2] = blue;

  // per-pixel colour contribution in the current mode
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      contrib[i] = gamma_enable ? LIN_TAB[codes[i]] : LINEAR_BITS'(codes[i]);
    end
  end

  assign in_area = (32'(col) < 2 * HALF_W) && (32'(row) < 2 * HALF_H);
  assign idx     = IDX_W'(col >> 1);

  // pair sums and unpacked line entry
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ps[i]     = PAIR_W'(pend_col[i]) + PAIR_W'(contrib[i]);
      ln_col[i] = line_rd[9 + i * PAIR_W +: PAIR_W];
    end
    ps_cov = 9'(pend_cov) + 9'(cov);
    ln_cov = line_rd[8:0];
  end

  // raster counters
  always_comb begin
    col_next = col + 1'b1;
    row_next = row;
    if (32'(col) == IN_WIDTH - 1) begin
      col_next = '0;
      row_next = row + 1'b1;
      if (32'(row) == IN_HEIGHT - 1) begin
        row_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col      <= '0;
      row      <= '0;
      pend_col <= '0;
      pend_cov <= '0;
    end else if (pix_valid) begin
      col <= col_next;
      row <= row_next;
      if (in_area && !col[0]) begin
        pend_col <= contrib;
        pend_cov <= cov;
      end
    end
  end

  // line buffer: read on the left pixel, write on the right pixel of even rows
  always_ff @(posedge clk) begin
    if (pix_valid && in_area && !col[0]) begin
      line_rd <= line_mem[idx];
    end
    if (pix_valid && in_area && col[0] && !row[0]) begin
      line_mem[idx] <= {ps[2], ps[1], ps[0], ps_cov};
    end
  end

  // block completion on the right pixel of odd rows
  always_comb begin
    blk_push = pix_valid && in_area && col[0] && row[0];
    for (int i = 0; i < 3; i++) begin
      blk.col[i] = BLK_W'(ps[i]) + BLK_W'(ln_col[i]);
    end
    blk.cov  = 10'(ps_cov) + 10'(ln_cov);
    blk.last = (32'(row) == 2 * HALF_H - 1) && (32'(col) == 2 * HALF_W - 1);
    blk.mode = gamma_enable;
  end

endmodule

@@ design/gbd_queue.sv @@
// short block queue between front and back
module gbd_queue import gbd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  blk_t wr,
  output logic full,
  input  logic pop,
  output logic nonempty,
  output blk_t rd
);

  blk_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wp;
  logic [QPTR_W-1:0] rp;
  logic [QCNT_W-1:0] cnt;

  assign full     = (32'(cnt) == QDEPTH);
  assign nonempty = (cnt != '0);
  assign rd       = mem[rp];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= wr;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) begin
        wp <= (32'(wp) == QDEPTH - 1) ? '0 : wp + 1'b1;
      end
      if (pop) begin
        rp <= (32'(rp) == QDEPTH - 1) ? '0 : rp + 1'b1;
      end
      cnt <= cnt + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full && !pop))
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> nonempty)
    else $error("pop from empty queue");
  a_level: assert property (@(posedge clk) disable iff (rst) 32'(cnt) <= QDEPTH)
    else $error("queue level out of range");

endmodule

@@ design/gbd_back.sv @@
// back end: pipelined threshold search, plain average and output register
module gbd_back import gbd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_nonempty,
  input  blk_t        q_rd,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_data,
  output logic        out_last
);

  localparam int NST = 8;

  logic [NST-1:0]       sv;
  blk_t                 sb [NST];
  logic [2:0][7:0]      sr [NST];
  logic                 ov;
  logic [2:0][7:0]      ocode;
  logic [7:0]           ocov;
  logic                 olast;
  logic                 adv;
  logic [2:0][7:0]      step [NST];
  logic [2:0][7:0]      plain;

  assign adv   = !ov || out_ready;
  assign q_pop = adv && q_nonempty;

  // one bit of the search per stage, msb first
  always_comb begin
    for (int s = 0; s < NST; s++) begin
      for (int i = 0; i < 3; i++) begin
        logic [7:0] cand;
        cand = sr[s][i] | (8'd1 << (NST - 1 - s));
        step[s][i] = ({THR_TAB[cand], 2'b00} <= sb[s].col[i]) ? cand : sr[s][i];
      end
    end
  end

  // plain rounded average with saturation
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic [BLK_W-1:0] a;
      a = (sb[NST-1].col[i] + BLK_W'(2)) >> 2;
      plain[i] = (a > BLK_W'(255)) ? 8'hFF : a[7:0];
    end
  end

  // pipeline advance
  always_ff @(posedge clk) begin
    if (rst) begin
      sv <= '0;
      ov <= 1'b0;
    end else if (adv) begin
      sv <= {sv[NST-2:0], q_nonempty};
      ov <= sv[NST-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sb[0] <= q_rd;
      sr[0] <= '0;
      for (int s = 1; s < NST; s++) begin
        sb[s] <= sb[s-1];
        sr[s] <= step[s-1];
      end
      ocode <= sb[NST-1].mode ? step[NST-1] : plain;
      ocov  <= 8'((sb[NST-1].cov + 10'd2) >> 2);
      olast <= sb[NST-1].last;
    end
  end

  assign out_valid = ov;
  assign out_data  = {ocov, ocode[2], ocode[1], ocode[0]};
  assign out_last  = olast;

  a_hold: assert property (@(posedge clk) disable iff (rst) ov && !out_ready |=> ov)
    else $error("result dropped while stalled");
  a_pop_flow: assert property (@(posedge clk) disable iff (rst) q_pop |=> sv[0])
    else $error("popped block not in pipeline");
  a_stall_keep: assert property (@(posedge clk) disable iff (rst)
      !adv |=> $stable(sv))
    else $error("pipeline moved while stalled");

endmodule

@@ tb/gbd_checker.sv @@
// checker for the gamma-correct box downscaler: watches the channels, predicts and compares
module gbd_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [0:0]  cfg_data,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [31:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,
  input  logic        m_tlast,
  output int          fails,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAME_W = gbd_pkg::IN_WIDTH;
  localparam int FRAME_H = gbd_pkg::IN_HEIGHT;
  localparam longint unsigned FULL_SCALE = (64'd1 << gbd_pkg::LINEAR_BITS) - 1;

  typedef struct {
    int unsigned colour[3];
    int unsigned cov;
  } pair_sum_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] cov;
    logic       last;
  } half_pixel_t;

  int unsigned linear_of_code[256];
  int unsigned midpoint_thr[256];
  pair_sum_t   line_sums[gbd_pkg::HALF_W];
  int unsigned left_pixel[4];
  int unsigned col_pos, row_pos;
  bit          gamma_on;
  half_pixel_t expected_pixels[$];

  // exact test of y - 1/2 <= full scale * (n/d)^2.2, by integer powers
  function automatic bit gamma_fits(longint unsigned y, longint unsigned n,
                                    longint unsigned d);
    logic [255:0] lhs, rhs, a, b;
    a = 256'(2 * y - 1) * 256'(d) * 256'(d);
    b = 256'(2 * FULL_SCALE) * 256'(n) * 256'(n);
    lhs = 256'(d);
    rhs = 256'(n);
    repeat (5) begin
      lhs = lhs * a;
      rhs = rhs * b;
    end
    return lhs <= rhs;
  endfunction

  function automatic int unsigned gamma_round(longint unsigned n, longint unsigned d);
    longint unsigned lo, hi, mid;
    lo = 0;
    hi = FULL_SCALE;
    while (lo < hi) begin
      mid = lo + (hi - lo + 1) / 2;
      if (gamma_fits(mid, n, d)) lo = mid;
      else hi = mid - 1;
    end
    return int'(lo);
  endfunction

  // colour code from a four-value sum, in the mode at emission
  function automatic logic [7:0] colour_code(int unsigned sum);
    int unsigned n;
    n = 0;
    if (gamma_on) begin
      for (int k = 1; k < 256; k++) begin
        if (4 * midpoint_thr[k] <= sum) n++;
      end
    end else begin
      n = (sum + 2) / 4;
      if (n > 255) n = 255;
    end
    return n[7:0];
  endfunction

  initial begin
    for (int c = 0; c < 256; c++) linear_of_code[c] = gamma_round(c, 255);
    midpoint_thr[0] = 0;
    for (int k = 1; k < 256; k++) midpoint_thr[k] = gamma_round(2 * k - 1, 510);
  end

  // prediction on accepted pixels, comparison on accepted results
  always @(posedge clk) begin
    int unsigned contrib[4];
    int unsigned sums[4];
    int unsigned idx;
    half_pixel_t exp_px, got;
    if (rst) begin
      col_pos = 0;
      row_pos = 0;
      gamma_on = 1;
      fails = 0;
      for (int i = 0; i < 4; i++) left_pixel[i] = 0;
      expected_pixels.delete();
    end else begin
      if (cfg_valid && cfg_ready) gamma_on = cfg_data[0];
      if (s_tvalid && s_tready) begin
        for (int i = 0; i < 3; i++) begin
          contrib[i] = gamma_on ? linear_of_code[s_tdata[8*i +: 8]] : s_tdata[8*i +: 8];
        end
        contrib[3] = s_tdata[31:24];
        if (col_pos[0] == 1'b0) begin
          left_pixel = contrib;
        end else begin
          idx = col_pos >> 1;
          for (int i = 0; i < 4; i++) sums[i] = left_pixel[i] + contrib[i];
          if (row_pos[0] == 1'b0) begin
            for (int i = 0; i < 3; i++) line_sums[idx].colour[i] = sums[i];
            line_sums[idx].cov = sums[3];
          end else begin
            exp_px.red   = colour_code(sums[0] + line_sums[idx].colour[0]);
            exp_px.green = colour_code(sums[1] + line_sums[idx].colour[1]);
            exp_px.blue  = colour_code(sums[2] + line_sums[idx].colour[2]);
            exp_px.cov   = 8'((sums[3] + line_sums[idx].cov + 2) / 4);
            exp_px.last  = (row_pos == FRAME_H - 1) && (col_pos == FRAME_W - 1);
            expected_pixels.push_back(exp_px);
          end
        end
        col_pos++;
        if (col_pos >= FRAME_W) begin
          col_pos = 0;
          row_pos++;
          if (row_pos >= FRAME_H) row_pos = 0;
        end
      end
      if (m_tvalid && m_tready) begin
        got.red   = m_tdata[7:0];
        got.green = m_tdata[15:8];
        got.blue  = m_tdata[23:16];
        got.cov   = m_tdata[31:24];
        got.last  = m_tlast;
        if (expected_pixels.size() == 0) begin
          fails++;
          if (fails <= 10) $display("unexpected result item data=%h last=%b", m_tdata, m_tlast);
        end else begin
          exp_px = expected_pixels.pop_front();
          if (got != exp_px) begin
            fails++;
            if (fails <= 10) begin
              $display("mismatch: expected r=%0d g=%0d b=%0d cov=%0d last=%0b",
                       exp_px.red, exp_px.green, exp_px.blue, exp_px.cov, exp_px.last);
              $display("          actual   r=%0d g=%0d b=%0d cov=%0d last=%0b",
                       got.red, got.green, got.blue, got.cov, got.last);
            end
          end
        end
      end
    end
    pending = expected_pixels.size();
  end
endmodule

@@ tb/tb.sv @@
// top of the downscaler testbench: clock, reset, pixel stimulus and verdict
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TOTAL_ITEMS = 750;
  localparam int DIRECTED_N  = 24;
  localparam int PRESSURE_AT = 260;

  logic        clk, rst;
  logic        cfg_valid, cfg_ready;
  logic [0:0]  cfg_data;
  logic        s_tvalid, s_tready;
  logic [31:0] s_tdata;               // red_in, green_in, blue_in, coverage_in
  logic        m_tvalid, m_tready;
  logic [31:0] m_tdata;               // red_out, green_out, blue_out, coverage_out
  logic        m_tlast;               // frame_last
  int          fails, pending;
  int          sent_count;
  int          send_idle, recv_idle;
  bit          pressure_done;
  int          hold_left;

  gamma_box_downscale dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  gbd_checker chk (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .fails(fails), .pending(pending)
  );

  // clock
  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // run limit
  initial begin
    #1ms;
    $display("status: fail");
    $finish;
  end

  // receiver side, with one long hold-off while the sender keeps going
  initial begin
    m_tready = 1'b0;
    hold_left = 0;
    pressure_done = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else if (!pressure_done && sent_count >= PRESSURE_AT) begin
        pressure_done = 1;
        hold_left = 400;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  // one pixel item, with random idle gaps
  task automatic send_pixel(input logic [31:0] px);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= px;
    do @(posedge clk); while (!s_tready);
    sent_count++;
    @(negedge clk);
  endtask

  // mode write once all results are in and the back end has drained
  task automatic write_mode(input logic mode);
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= mode;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // byte biased towards the extremes now and then
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(9))
      0: return 8'h00;
      1: return 8'hff;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  initial begin
    logic [31:0] px;
    logic [7:0] edge_vals[4];
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_data = 1'b0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    sent_count = 0;
    send_idle = 10;
    recv_idle = 78;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed extremes and walking bits on the first pixels
    edge_vals = '{8'h00, 8'hff, 8'h01, 8'hfe};
    for (int i = 0; i < DIRECTED_N; i++) begin
      if (i < 16) px = {edge_vals[i % 4], edge_vals[(i / 4) % 4], edge_vals[i % 4],
                        edge_vals[(i + 1) % 4]};
      else px = 32'h1 << (4 * (i - 16)) | 32'h8000_0000 >> (4 * (i - 16));
      send_pixel(px);
    end
    write_mode(1'b1);

    // random pixels over the first rows, results come from the odd row
    while (sent_count < TOTAL_ITEMS) begin
      if (sent_count == 200) write_mode(1'b0);
      else if (sent_count == 330) write_mode(1'b1);
      else if (sent_count == 401) write_mode(1'b0);
      else if (sent_count == 470) write_mode(1'b1);
      if (sent_count < 340) begin
        send_idle = 10;
        recv_idle = 78;
      end else if (sent_count < 430) begin
        send_idle = 78;
        recv_idle = 10;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      send_pixel({pick_byte(), pick_byte(), pick_byte(), pick_byte()});
    end
    s_tvalid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (30) @(negedge clk);
    if (fails == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
design/gbd_pkg.sv
design/gbd_front.sv
design/gbd_queue.sv
design/gbd_back.sv
design/gamma_box_downscale.sv
tb/gbd_checker.sv
tb/tb.sv
